// ===== design/bafp_pkg.sv =====
// ----------------------------------------------------------------------------
// bafp_pkg
// Types and constants shared by the auxiliary field parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bafp_pkg;

   // type characters
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_C = 8'h43;
   localparam logic [7:0] CH_UPPER_S = 8'h53;
   localparam logic [7:0] CH_UPPER_I = 8'h49;
   localparam logic [7:0] CH_LOWER_I = 8'h69;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_D = 8'h64;
   localparam logic [7:0] CH_UPPER_H = 8'h48;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_C = 8'h63;
   localparam logic [7:0] CH_LOWER_S = 8'h73;

   typedef enum logic [2:0] {
      KIND_CHAR    = 3'd0,
      KIND_INT     = 3'd1,
      KIND_FLOAT   = 3'd2,
      KIND_DOUBLE  = 3'd3,
      KIND_STR_BYTE = 3'd4,
      KIND_STR_END = 3'd5,
      KIND_UNKNOWN = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      EXT_ZERO8  = 3'd0,
      EXT_ZERO16 = 3'd1,
      EXT_SIGN8  = 3'd2,
      EXT_SIGN16 = 3'd3,
      EXT_RAW32  = 3'd4,
      EXT_RAW64  = 3'd5
   } ext_type;

   typedef enum logic [2:0] {
      PH_TAG1   = 3'd0,
      PH_TAG2   = 3'd1,
      PH_TYPE   = 3'd2,
      PH_VALUE  = 3'd3,
      PH_STRING = 3'd4
   } phase_type;

   // decode of a byte taken as a type character
   typedef struct packed {
      logic     is_str;
      logic     is_hex;
      logic [3:0] vlen;
      kind_type vkind;
      ext_type  ext;
   } class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_end;
      class_type  cls;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/bafp_req_if.sv =====
// ----------------------------------------------------------------------------
// bafp_req_if
// Byte channel into the auxiliary field parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface bafp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       block_end;

   modport source (output valid, output data_byte, output block_end, input ready);
   modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

`default_nettype wire

// ===== design/bafp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bafp_rsp_if
// Result channel out of the auxiliary field parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface bafp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  tag_first;
   logic [7:0]  tag_second;
   logic [2:0]  kind;
   logic [7:0]  type_byte;
   logic [63:0] value;
   logic        was_hex;
   logic        truncated;
   logic        block_done;

   modport source (
      output valid, output tag_first, output tag_second, output kind,
      output type_byte, output value, output was_hex, output truncated,
      output block_done, input ready
   );
   modport sink (
      input valid, input tag_first, input tag_second, input kind,
      input type_byte, input value, input was_hex, input truncated,
      input block_done, output ready
   );
endinterface

`default_nettype wire

// ===== design/bafp_front.sv =====
// ----------------------------------------------------------------------------
// bafp_front
// Accepts bytes and decodes each one as a possible type character.
// ----------------------------------------------------------------------------
`default_nettype none

module bafp_front (
   bafp_req_if.sink          req,
   input  logic              q_full,
   output logic              push,
   output bafp_pkg::entry_type push_entry
);
   import bafp_pkg::*;

   class_type cls;

   always_comb begin
      cls = '{is_str: 1'b0, is_hex: 1'b0, vlen: 4'd0, vkind: KIND_INT, ext: EXT_RAW32};
      case (req.data_byte)
         CH_UPPER_Z: begin
            cls.is_str = 1'b1;
         end
         CH_UPPER_H: begin
            cls.is_str = 1'b1;
            cls.is_hex = 1'b1;
         end
         CH_UPPER_A: begin
            cls.vlen  = 4'd1;
            cls.vkind = KIND_CHAR;
            cls.ext   = EXT_ZERO8;
         end
         CH_UPPER_C: begin
            cls.vlen = 4'd1;
            cls.ext  = EXT_ZERO8;
         end
         CH_LOWER_C: begin
            cls.vlen = 4'd1;
            cls.ext  = EXT_SIGN8;
         end
         CH_UPPER_S: begin
            cls.vlen = 4'd2;
            cls.ext  = EXT_ZERO16;
         end
         CH_LOWER_S: begin
            cls.vlen = 4'd2;
            cls.ext  = EXT_SIGN16;
         end
         CH_UPPER_I, CH_LOWER_I: begin
            cls.vlen = 4'd4;
         end
         CH_LOWER_F: begin
            cls.vlen  = 4'd4;
            cls.vkind = KIND_FLOAT;
         end
         CH_LOWER_D: begin
            cls.vlen  = 4'd8;
            cls.vkind = KIND_DOUBLE;
            cls.ext   = EXT_RAW64;
         end
         default: begin
            cls.vlen = 4'd0;
         end
      endcase
   end

   assign req.ready  = !q_full;
   assign push       = req.valid && !q_full;
   assign push_entry = '{data_byte: req.data_byte, block_end: req.block_end, cls: cls};

endmodule

`default_nettype wire

// ===== design/bafp_queue.sv =====
// ----------------------------------------------------------------------------
// bafp_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bafp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bafp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output bafp_pkg::entry_type head_entry
);
   import bafp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

// ===== design/bafp_back.sv =====
// ----------------------------------------------------------------------------
// bafp_back
// Field state machine: gathers tags, type and value bytes, registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module bafp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  bafp_pkg::entry_type head_entry,
   output logic                pop,
   bafp_rsp_if.source          rsp
);
   import bafp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  tag1_ff, tag1_in;
   logic [7:0]  tag2_ff, tag2_in;
   logic [7:0]  type_ff, type_in;
   class_type   cls_ff, cls_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] acc_ff, acc_in;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_tag1_ff;
   logic [7:0]  rsp_tag2_ff;
   kind_type    rsp_kind_ff;
   logic [7:0]  rsp_type_ff;
   logic [63:0] rsp_value_ff;
   logic        rsp_hex_ff;
   logic        rsp_trunc_ff;
   logic        rsp_done_ff;

   logic [7:0]  b;
   logic        value_last;
   logic [63:0] acc_merge;
   logic        have;
   kind_type    kind;
   logic [63:0] val;
   logic        hex;
   logic        out_free;
   logic        advance;
   phase_type   phase_field;

   assign b          = head_entry.data_byte;
   assign value_last = ({1'b0, idx_ff} == (cls_ff.vlen - 4'd1));
   assign acc_merge  = acc_ff | (64'(b) << {idx_ff, 3'b000});
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign advance    = head_valid && (!have || out_free);
   assign pop        = advance;

   // next state: phase at end of the field logic, then block end forces tag1
   always_comb begin
      phase_field = phase_ff;
      case (phase_ff)
         PH_TAG1: phase_field = PH_TAG2;
         PH_TAG2: phase_field = PH_TYPE;
         PH_TYPE: begin
            if (head_entry.cls.is_str) begin
               phase_field = PH_STRING;
            end else if (head_entry.cls.vlen == 4'd0) begin
               phase_field = PH_TAG1;
            end else begin
               phase_field = PH_VALUE;
            end
         end
         PH_VALUE: phase_field = value_last ? PH_TAG1 : PH_VALUE;
         PH_STRING: phase_field = (b == 8'd0) ? PH_TAG1 : PH_STRING;
         default: phase_field = PH_TAG1;
      endcase
      phase_in = head_entry.block_end ? PH_TAG1 : phase_field;
   end

   // outputs and datapath updates
   always_comb begin
      tag1_in = tag1_ff;
      tag2_in = tag2_ff;
      type_in = type_ff;
      cls_in  = cls_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      have    = 1'b0;
      kind    = KIND_UNKNOWN;
      val     = '0;
      hex     = 1'b0;
      case (phase_ff)
         PH_TAG1: begin
            tag1_in = b;
            tag2_in = '0;
            type_in = '0;
         end
         PH_TAG2: begin
            tag2_in = b;
         end
         PH_TYPE: begin
            type_in = b;
            cls_in  = head_entry.cls;
            idx_in  = '0;
            acc_in  = '0;
            if (!head_entry.cls.is_str && head_entry.cls.vlen == 4'd0) begin
               have = 1'b1;
            end
         end
         PH_VALUE: begin
            acc_in = acc_merge;
            idx_in = idx_ff + 3'd1;
            if (value_last) begin
               have = 1'b1;
               kind = cls_ff.vkind;
               case (cls_ff.ext)
                  EXT_ZERO8:  val = {56'd0, acc_merge[7:0]};
                  EXT_ZERO16: val = {48'd0, acc_merge[15:0]};
                  EXT_SIGN8:  val = {32'd0, {24{acc_merge[7]}}, acc_merge[7:0]};
                  EXT_SIGN16: val = {32'd0, {16{acc_merge[15]}}, acc_merge[15:0]};
                  EXT_RAW64:  val = acc_merge;
                  default:    val = {32'd0, acc_merge[31:0]};
               endcase
            end
         end
         PH_STRING: begin
            have = 1'b1;
            hex  = cls_ff.is_hex;
            if (b == 8'd0) begin
               kind = KIND_STR_END;
            end else begin
               kind = KIND_STR_BYTE;
               val  = 64'(b);
            end
         end
         default: begin
            tag1_in = b;
            tag2_in = '0;
            type_in = '0;
         end
      endcase
      // block end with no result of its own: report an empty unknown result
      if (head_entry.block_end && !have) begin
         have = 1'b1;
         kind = KIND_UNKNOWN;
         val  = '0;
         hex  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff <= phase_in;
         end
         if (advance && have) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag2_in;
         type_ff <= type_in;
         cls_ff  <= cls_in;
         idx_ff  <= idx_in;
         acc_ff  <= acc_in;
      end
      if (advance && have) begin
         rsp_tag1_ff  <= tag1_in;
         rsp_tag2_ff  <= tag2_in;
         rsp_kind_ff  <= kind;
         rsp_type_ff  <= type_in;
         rsp_value_ff <= val;
         rsp_hex_ff   <= hex;
         rsp_trunc_ff <= head_entry.block_end && (phase_field != PH_TAG1);
         rsp_done_ff  <= head_entry.block_end;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.tag_first  = rsp_tag1_ff;
   assign rsp.tag_second = rsp_tag2_ff;
   assign rsp.kind       = rsp_kind_ff;
   assign rsp.type_byte  = rsp_type_ff;
   assign rsp.value      = rsp_value_ff;
   assign rsp.was_hex    = rsp_hex_ff;
   assign rsp.truncated  = rsp_trunc_ff;
   assign rsp.block_done = rsp_done_ff;

   a_block_end_tag1: assert property (@(posedge clock) disable iff (reset)
      (advance && head_entry.block_end) |=> phase_ff == PH_TAG1)
      else $error("block end did not return to first tag");
   a_trunc_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_trunc_ff) |-> rsp_done_ff)
      else $error("truncation without block end");
   a_hex_string: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hex_ff) |->
         (rsp_kind_ff == KIND_STR_BYTE || rsp_kind_ff == KIND_STR_END))
      else $error("hex flag on a non-string result");
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_UNKNOWN) |-> rsp_value_ff == '0)
      else $error("unknown result with nonzero value");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff)
      else $error("pending result dropped");

endmodule

`default_nettype wire

// ===== design/bam_aux_field_parser_unit.sv =====
// ----------------------------------------------------------------------------
// bam_aux_field_parser_unit
// Auxiliary field parser: one block byte in, at most one field result out.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    data_byte[7:0], block_end
//   rsp_chan  out  valid/ready    tag_first, tag_second, kind, type_byte,
//                                 value[63:0], was_hex, truncated, block_done
//
// One byte per cycle sustained while results are taken; an accepted byte goes
// into a queue slot, and from the queue head its result is registered.
// The field state machine takes one queued byte per cycle, but a byte with a
// result waits while the output stalls; bytes with none drain from the queue.
// Reset (synchronous) empties the queue and returns to the first tag byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bam_aux_field_parser_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   bafp_req_if.sink    req_chan,
   bafp_rsp_if.source  rsp_chan
);
   import bafp_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      q_full;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   bafp_front u_front (
      .req        (req_chan),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   bafp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   bafp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives auxiliary field bytes into the parser with random idle cycles on the
// byte side and random stalls on the result side. A field tracker follows the
// field structure byte by byte and checks every result beat in order.
// ----------------------------------------------------------------------------

module tb_top;
   import bafp_pkg::*;

   typedef struct packed {
      logic [7:0]  tag_first;
      logic [7:0]  tag_second;
      kind_type    kind;
      logic [7:0]  type_byte;
      logic [63:0] value;
      logic        was_hex;
      logic        truncated;
      logic        block_done;
   } aux_result_type;

   class field_tracker;
      phase_type      phase;
      logic [7:0]     tag_a;
      logic [7:0]     tag_b;
      logic [7:0]     type_ch;
      logic [3:0]     left;
      logic [63:0]    acc;
      aux_result_type expected_fields[$];
      int             mismatches;

      function new();
         phase      = PH_TAG1;
         tag_a      = 8'h00;
         tag_b      = 8'h00;
         type_ch    = 8'h00;
         left       = 4'd0;
         acc        = 64'd0;
         mismatches = 0;
      endfunction

      function logic [3:0] value_bytes(input logic [7:0] t);
         case (t)
            CH_UPPER_A, CH_UPPER_C, CH_LOWER_C: return 4'd1;
            CH_UPPER_S, CH_LOWER_S: return 4'd2;
            CH_LOWER_I, CH_UPPER_I, CH_LOWER_F: return 4'd4;
            CH_LOWER_D: return 4'd8;
            default: return 4'd0;
         endcase
      endfunction

      // Advance the field state by one accepted byte and queue its result, if any.
      function void note_byte(input logic [7:0] b, input logic last);
         aux_result_type r;
         logic           have;
         logic [3:0]     n;
         logic [2:0]     idx;
         have      = 1'b0;
         r         = '0;
         r.kind    = KIND_UNKNOWN;
         case (phase)
            PH_TAG2: begin
               tag_b = b;
               phase = PH_TYPE;
            end
            PH_TYPE: begin
               type_ch = b;
               if (b == CH_UPPER_Z || b == CH_UPPER_H) begin
                  phase = PH_STRING;
               end else if (value_bytes(b) == 4'd0) begin
                  have  = 1'b1;
                  phase = PH_TAG1;
               end else begin
                  left  = value_bytes(b);
                  acc   = 64'd0;
                  phase = PH_VALUE;
               end
            end
            PH_VALUE: begin
               n = value_bytes(type_ch);
               if (n == 4'd0) n = 4'd1;
               if (left == 4'd0 || left > n) left = n;
               idx  = 3'(n - left);
               acc  = acc | (64'(b) << (8 * idx));
               left = left - 4'd1;
               if (left == 4'd0) begin
                  have  = 1'b1;
                  phase = PH_TAG1;
                  case (type_ch)
                     CH_UPPER_A: begin
                        r.kind  = KIND_CHAR;
                        r.value = {56'd0, acc[7:0]};
                     end
                     CH_UPPER_C: begin
                        r.kind  = KIND_INT;
                        r.value = {56'd0, acc[7:0]};
                     end
                     CH_LOWER_C: begin
                        r.kind  = KIND_INT;
                        r.value = {32'd0, {24{acc[7]}}, acc[7:0]};
                     end
                     CH_UPPER_S: begin
                        r.kind  = KIND_INT;
                        r.value = {48'd0, acc[15:0]};
                     end
                     CH_LOWER_S: begin
                        r.kind  = KIND_INT;
                        r.value = {32'd0, {16{acc[15]}}, acc[15:0]};
                     end
                     CH_LOWER_F: begin
                        r.kind  = KIND_FLOAT;
                        r.value = {32'd0, acc[31:0]};
                     end
                     CH_LOWER_D: begin
                        r.kind  = KIND_DOUBLE;
                        r.value = acc;
                     end
                     default: begin
                        r.kind  = KIND_INT;
                        r.value = {32'd0, acc[31:0]};
                     end
                  endcase
               end
            end
            PH_STRING: begin
               have      = 1'b1;
               r.was_hex = (type_ch == CH_UPPER_H);
               if (b == 8'h00) begin
                  r.kind = KIND_STR_END;
                  phase  = PH_TAG1;
               end else begin
                  r.kind  = KIND_STR_BYTE;
                  r.value = {56'd0, b};
               end
            end
            default: begin
               tag_a   = b;
               tag_b   = 8'h00;
               type_ch = 8'h00;
               phase   = PH_TAG2;
            end
         endcase

         // a block end inside a field still produces a beat, flagged as truncated
         if (last) begin
            r.truncated = (phase != PH_TAG1);
            if (!have) begin
               have      = 1'b1;
               r.kind    = KIND_UNKNOWN;
               r.value   = 64'd0;
               r.was_hex = 1'b0;
            end
            phase = PH_TAG1;
            left  = 4'd0;
            acc   = 64'd0;
         end

         if (have) begin
            r.tag_first  = tag_a;
            r.tag_second = tag_b;
            r.type_byte  = type_ch;
            r.block_done = last;
            expected_fields = {expected_fields, r};
         end
      endfunction

      function void flag(input string msg);
         mismatches++;
         if (mismatches <= 10) $display("%t ERROR %s", $realtime, msg);
      endfunction

      function void check_field(input aux_result_type got);
         aux_result_type want;
         if (expected_fields.size() == 0) begin
            flag($sformatf("result beat with nothing pending: %p", got));
            return;
         end
         want = expected_fields.pop_front();
         if (got.tag_first !== want.tag_first || got.tag_second !== want.tag_second ||
             got.kind !== want.kind || got.type_byte !== want.type_byte ||
             got.value !== want.value || got.was_hex !== want.was_hex ||
             got.truncated !== want.truncated || got.block_done !== want.block_done)
            flag($sformatf("field mismatch\n  exp %p\n  got %p", want, got));
      endfunction
   endclass

   localparam logic [7:0] FIELD_TYPES [11] = '{
      CH_UPPER_A, CH_LOWER_C, CH_UPPER_C, CH_LOWER_S, CH_UPPER_S, CH_LOWER_I,
      CH_UPPER_I, CH_LOWER_F, CH_LOWER_D, CH_UPPER_Z, CH_UPPER_H
   };
   localparam int TOTAL_BYTES = 1900;

   logic clock = 1'b0;
   logic reset;
   int   bytes_sent;
   bit   steady;

   bafp_req_if req_bus();
   bafp_rsp_if rsp_bus();

   field_tracker sb = new();

   bam_aux_field_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function bit take_break();
      return !steady && ($urandom_range(0, 99) < 13);
   endfunction

   always @(posedge clock) begin
      rsp_bus.ready <= !take_break();
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_byte(req_bus.data_byte, req_bus.block_end);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_field('{rsp_bus.tag_first, rsp_bus.tag_second, kind_type'(rsp_bus.kind),
                          rsp_bus.type_byte, rsp_bus.value, rsp_bus.was_hex,
                          rsp_bus.truncated, rsp_bus.block_done});
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      while (take_break()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.block_end <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      // hold both sides busy through one long window
      steady = (bytes_sent >= 700 && bytes_sent < 1100);
   endtask

   // One whole field with random tags and value; optionally close the record
   // on its last byte, or chop it at a random byte.
   task automatic push_field(input logic [7:0] ty, input logic close_rec, input logic chop);
      logic [7:0] seq[$];
      int         len;
      int         cut;
      seq = {seq, 8'($urandom)};
      seq = {seq, 8'($urandom)};
      seq = {seq, ty};
      if (ty == CH_UPPER_Z || ty == CH_UPPER_H) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 5);
         repeat (len) seq = {seq, 8'($urandom_range(1, 255))};
         seq = {seq, 8'h00};
      end else begin
         repeat (sb.value_bytes(ty)) seq = {seq, 8'($urandom)};
      end
      cut = chop ? $urandom_range(0, seq.size() - 1) : -1;
      foreach (seq[i]) begin
         push_byte(seq[i], i == cut || (close_rec && i == seq.size() - 1));
         if (i == cut) break;
      end
   endtask

   initial begin
      int         pick;
      logic [7:0] ty;
      reset             = 1'b1;
      steady            = 1'b0;
      bytes_sent        = 0;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.block_end = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // S field closing the block exactly on its last value byte
      push_byte("S", 0); push_byte("S", 0); push_byte(CH_UPPER_S, 0);
      push_byte(8'hFF, 0); push_byte(8'hFF, 1);
      // block ends on a first tag, a second tag, and a known type byte
      push_byte("Q", 1);
      push_byte("Q", 0); push_byte("R", 1);
      push_byte("Q", 0); push_byte("R", 0); push_byte(CH_LOWER_I, 1);
      // block ends in the middle of a double
      push_byte("D", 0); push_byte("D", 0); push_byte(CH_LOWER_D, 0);
      push_byte(8'h11, 0); push_byte(8'h22, 1);
      // hex string with one character
      push_byte("H", 0); push_byte("X", 0); push_byte(CH_UPPER_H, 0);
      push_byte(8'hFF, 0); push_byte(8'h00, 0);
      // unknown type, extreme tag values
      push_byte(8'h00, 0); push_byte(8'hFF, 0); push_byte(8'h00, 0);
      // block ends on a string character
      push_byte("U", 0); push_byte("U", 0); push_byte(CH_UPPER_Z, 0);
      push_byte("a", 1);

      while (bytes_sent < TOTAL_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            push_byte(8'($urandom), $urandom_range(0, 7) == 0);
         end else begin
            ty = ($urandom_range(0, 99) < 6) ? 8'($urandom)
                                              : FIELD_TYPES[$urandom_range(0, 10)];
            push_field(ty, $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 5);
         end
      end
      req_bus.valid <= 1'b0;

      while (sb.expected_fields.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_fields.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
